// ===== rtl/core/neural_rate_model_step_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the firing-rate network step block
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef NEURAL_RATE_MODEL_STEP_ASSERT_SVH
`define NEURAL_RATE_MODEL_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
// check a property at every edge outside reset
`define NRMS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check a property at every edge, reset included
`define NRMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NRMS_ASSERT(lbl, clk, rstn, prop, msg)
`define NRMS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/nrms_pkg.sv =====
// ----------------------------------------------------------------------------
// nrms_pkg
// Sizes, request codes, payload structs and controller interface types for
// the firing-rate network step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrms_pkg;

	localparam int GROUPS     = 8;
	localparam int VALUE_BITS = 24;

	localparam int FIELD_W = 24;
	localparam int GIDX_W  = 3;
	localparam int GAIN_W  = 16;
	localparam int FRAC_W  = 16;

	localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int WDEPTH  = GROUPS * GROUPS;
	localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

	// accumulator and update widths
	localparam int PROD_W = 2 * VALUE_BITS;
	localparam int ACC_W  = PROD_W + GRP_W;
	localparam int SUM_W  = (((ACC_W - FRAC_W) > VALUE_BITS) ? (ACC_W - FRAC_W) : VALUE_BITS) + 1;
	localparam int DIFF_W = VALUE_BITS + 1;
	localparam int PRD_W  = DIFF_W + GAIN_W + 1;
	localparam int INC_W  = PRD_W - FRAC_W;
	localparam int NEW_W  = INC_W + 1;
	localparam int EXT_W  = ((FIELD_W > VALUE_BITS) ? FIELD_W : VALUE_BITS) + 1;

	localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(GROUPS - 1);

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [GRP_W-1:0]             grp_t;

	typedef enum logic [1:0] {
		REQ_WEIGHT = 2'd0,
		REQ_GROUP  = 2'd1,
		REQ_STEP   = 2'd2
	} req_kind_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic [GIDX_W-1:0]         target_group;
		logic [GIDX_W-1:0]         source_group;
		logic signed [FIELD_W-1:0] value;
		logic signed [FIELD_W-1:0] drive;
		logic [GAIN_W-1:0]         gain;
	} req_t;

	typedef struct packed {
		logic [GIDX_W-1:0]         group_out;
		logic signed [FIELD_W-1:0] rate_out;
		logic                      last_out;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mac;
		logic commit;
		logic emit;
		grp_t row;
		grp_t col;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic out_free;
	} sts_t;

	// sign-extend a field and clamp it to the stored value range
	function automatic val_t sat_field(input logic signed [FIELD_W-1:0] x);
		logic signed [EXT_W-1:0] e;
		logic signed [EXT_W-1:0] vmax;
		logic signed [EXT_W-1:0] vmin;
		e    = EXT_W'(x);
		vmax = {{(EXT_W - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
		vmin = ~vmax;
		if (e > vmax) begin
			sat_field = vmax[VALUE_BITS-1:0];
		end else if (e < vmin) begin
			sat_field = vmin[VALUE_BITS-1:0];
		end else begin
			sat_field = e[VALUE_BITS-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/nrms_datapath.sv =====
// ----------------------------------------------------------------------------
// nrms_datapath
// Weight memory, group registers, multiply-accumulate pipeline, Euler update
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neural_rate_model_step_assert.svh"

module nrms_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  nrms_pkg::req_t  req,
	input  nrms_pkg::cmd_t  cmd,
	input  logic            rsp_stall,
	output nrms_pkg::sts_t  sts,
	output logic            rsp_valid,
	output nrms_pkg::rsp_t  rsp
);

	localparam int VB = nrms_pkg::VALUE_BITS;

	localparam logic signed [nrms_pkg::SUM_W-1:0] VMAX_SUM =
		{{(nrms_pkg::SUM_W - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
	localparam logic signed [nrms_pkg::NEW_W-1:0] VMAX_NEW =
		{{(nrms_pkg::NEW_W - VB + 1){1'b0}}, {(VB - 1){1'b1}}};
	localparam logic signed [nrms_pkg::NEW_W-1:0] VMIN_NEW = ~VMAX_NEW;

	// storage
	nrms_pkg::val_t               wmem [nrms_pkg::WDEPTH];
	logic [nrms_pkg::WDEPTH-1:0]  wvld_q;
	nrms_pkg::val_t               rate_q  [nrms_pkg::GROUPS];
	nrms_pkg::val_t               next_q  [nrms_pkg::GROUPS];
	nrms_pkg::val_t               drive_q [nrms_pkg::GROUPS];
	logic [nrms_pkg::GAIN_W-1:0]  gain_q  [nrms_pkg::GROUPS];

	// load decode
	logic                         tgt_ok;
	logic                         src_ok;
	logic                         wr_weight;
	logic                         wr_group;
	nrms_pkg::grp_t               tgt;
	logic [nrms_pkg::WADDR_W-1:0] waddr;
	logic [nrms_pkg::WADDR_W-1:0] raddr;

	// multiply-accumulate pipeline
	logic                         v_s1;
	nrms_pkg::val_t               w_raw_s1;
	logic                         wok_s1;
	nrms_pkg::val_t               r_s1;
	logic                         first_s1;
	logic                         last_s1;
	logic                         diag_s1;
	nrms_pkg::grp_t               row_s1;
	nrms_pkg::val_t               w_s1;

	logic                         v_s2;
	logic signed [nrms_pkg::PROD_W-1:0] prod_s2;
	nrms_pkg::val_t               r_s2;
	logic                         first_s2;
	logic                         last_s2;
	logic                         diag_s2;
	nrms_pkg::grp_t               row_s2;

	logic signed [nrms_pkg::ACC_W-1:0] acc_q;
	logic signed [nrms_pkg::ACC_W-1:0] acc_base;
	nrms_pkg::val_t               old_q;
	logic                         done_s3;
	nrms_pkg::grp_t               row_s3;

	// update stages
	logic signed [nrms_pkg::SUM_W-1:0] sum_raw;
	nrms_pkg::val_t               sum_clamp;
	logic                         v_f1;
	nrms_pkg::val_t               sum_f1;
	nrms_pkg::val_t               old_f1;
	nrms_pkg::grp_t               row_f1;

	logic signed [nrms_pkg::DIFF_W-1:0]    diff;
	logic signed [nrms_pkg::GAIN_W:0]      gain_s;
	logic                         v_f2;
	logic signed [nrms_pkg::PRD_W-1:0]     prd_f2;
	nrms_pkg::val_t               old_f2;
	nrms_pkg::grp_t               row_f2;

	logic signed [nrms_pkg::INC_W-1:0]     inc;
	logic signed [nrms_pkg::NEW_W-1:0]     nxt_raw;
	nrms_pkg::val_t               nxt_sat;

	logic                         rsp_valid_q;
	nrms_pkg::rsp_t               rsp_q;

	assign tgt_ok    = 32'(req.target_group) < nrms_pkg::GROUPS;
	assign src_ok    = 32'(req.source_group) < nrms_pkg::GROUPS;
	assign wr_weight = cmd.load && (req.req_type == nrms_pkg::REQ_WEIGHT) && tgt_ok && src_ok;
	assign wr_group  = cmd.load && (req.req_type == nrms_pkg::REQ_GROUP) && tgt_ok;
	assign tgt       = nrms_pkg::GRP_W'(req.target_group);
	assign waddr     = nrms_pkg::WADDR_W'(32'(req.source_group) * nrms_pkg::GROUPS
		+ 32'(req.target_group));
	assign raddr     = nrms_pkg::WADDR_W'(32'(cmd.col) * nrms_pkg::GROUPS + 32'(cmd.row));

	// weight memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_weight) begin
			wmem[waddr] <= nrms_pkg::sat_field(req.value);
		end
	end

	always_ff @(posedge clk) begin
		w_raw_s1 <= wmem[raddr];
	end

	// an entry never written reads as zero
	assign w_s1     = wok_s1 ? w_raw_s1 : '0;
	assign acc_base = first_s2 ? '0 : acc_q;

	// floor the Q19.32 sum to 16 fraction bits, add the drive, rectify and clamp to Q8.16
	assign sum_raw = nrms_pkg::SUM_W'(signed'(acc_q[nrms_pkg::ACC_W-1:nrms_pkg::FRAC_W]))
		+ nrms_pkg::SUM_W'(drive_q[row_s3]);

	always_comb begin
		if (sum_raw < 0) begin
			sum_clamp = '0;
		end else if (sum_raw > VMAX_SUM) begin
			sum_clamp = VMAX_SUM[VB-1:0];
		end else begin
			sum_clamp = sum_raw[VB-1:0];
		end
	end

	assign diff   = nrms_pkg::DIFF_W'(sum_f1) - nrms_pkg::DIFF_W'(old_f1);
	assign gain_s = signed'({1'b0, gain_q[row_f1]});

	assign inc     = signed'(prd_f2[nrms_pkg::PRD_W-1:nrms_pkg::FRAC_W]);
	assign nxt_raw = nrms_pkg::NEW_W'(old_f2) + nrms_pkg::NEW_W'(inc);

	always_comb begin
		if (nxt_raw > VMAX_NEW) begin
			nxt_sat = VMAX_NEW[VB-1:0];
		end else if (nxt_raw < VMIN_NEW) begin
			nxt_sat = VMIN_NEW[VB-1:0];
		end else begin
			nxt_sat = nxt_raw[VB-1:0];
		end
	end

	// control state and group registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			done_s3     <= 1'b0;
			v_f1        <= 1'b0;
			v_f2        <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int g = 0; g < nrms_pkg::GROUPS; g++) begin
				rate_q[g]  <= '0;
				next_q[g]  <= '0;
				drive_q[g] <= '0;
				gain_q[g]  <= '0;
			end
		end else begin
			v_s1    <= cmd.mac;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && last_s2;
			v_f1    <= done_s3;
			v_f2    <= v_f1;

			if (wr_weight) begin
				wvld_q[waddr] <= 1'b1;
			end
			if (wr_group) begin
				rate_q[tgt]  <= nrms_pkg::sat_field(req.value);
				drive_q[tgt] <= nrms_pkg::sat_field(req.drive);
				gain_q[tgt]  <= req.gain;
			end
			if (v_f2) begin
				next_q[row_f2] <= nxt_sat;
			end
			// all new rates are in: make them the current ones
			if (cmd.commit) begin
				for (int g = 0; g < nrms_pkg::GROUPS; g++) begin
					rate_q[g] <= next_q[g];
				end
			end

			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		wok_s1   <= wvld_q[raddr];
		r_s1     <= rate_q[cmd.col];
		first_s1 <= cmd.col == '0;
		last_s1  <= cmd.col == nrms_pkg::LAST_GRP;
		diag_s1  <= cmd.col == cmd.row;
		row_s1   <= cmd.row;

		prod_s2  <= w_s1 * r_s1;
		r_s2     <= r_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		diag_s2  <= diag_s1;
		row_s2   <= row_s1;

		if (v_s2) begin
			acc_q  <= acc_base + nrms_pkg::ACC_W'(prod_s2);
			row_s3 <= row_s2;
		end
		// hold the old rate of the row seen on the diagonal
		if (v_s2 && diag_s2) begin
			old_q <= r_s2;
		end

		sum_f1 <= sum_clamp;
		old_f1 <= old_q;
		row_f1 <= row_s3;

		prd_f2 <= gain_s * diff;
		old_f2 <= old_f1;
		row_f2 <= row_f1;

		if (cmd.emit) begin
			rsp_q.group_out <= nrms_pkg::GIDX_W'(cmd.row);
			rsp_q.rate_out  <= nrms_pkg::FIELD_W'(next_q[cmd.row]);
			rsp_q.last_out  <= cmd.row == nrms_pkg::LAST_GRP;
		end
	end

	assign sts.busy     = v_s1 || v_s2 || done_s3 || v_f1 || v_f2;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

	`NRMS_ASSERT(a_emit_slot_free, clk, arst_n, cmd.emit |-> (!rsp_valid_q || !rsp_stall), "result register overwritten while a transaction waits")
	`NRMS_ASSERT(a_commit_drained, clk, arst_n, cmd.commit |-> !(v_s1 || v_s2 || done_s3 || v_f1 || v_f2), "rates committed with the update pipeline still busy")
	`NRMS_ASSERT(a_no_emit_midstep, clk, arst_n, (v_f1 || v_f2) |-> !(cmd.emit || cmd.commit), "result emitted before all new rates were written")
	`NRMS_ASSERT(a_load_quiet, clk, arst_n, cmd.load |-> !(v_s1 || v_s2 || done_s3 || cmd.mac), "store written while a step is running")

endmodule

// ===== rtl/core/nrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// nrms_ctrl
// Sequencer for one step: walks the weight matrix row by row, waits for the
// update pipeline, commits the new rates and emits one result per group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_type,
	input  nrms_pkg::sts_t sts,
	output logic           req_stall,
	output nrms_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t         state_q;
	nrms_pkg::grp_t row_q;
	nrms_pkg::grp_t col_q;
	logic           accept;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = state_q != ST_IDLE;

	assign cmd.load   = accept;
	assign cmd.mac    = state_q == ST_MAC;
	assign cmd.commit = (state_q == ST_DRAIN) && !sts.busy;
	assign cmd.emit   = (state_q == ST_EMIT) && sts.out_free;
	assign cmd.row    = row_q;
	assign cmd.col    = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == nrms_pkg::REQ_STEP)) begin
						state_q <= ST_MAC;
						row_q   <= '0;
						col_q   <= '0;
					end
				end
				ST_MAC: begin
					// advance source first, then target row
					if (col_q == nrms_pkg::LAST_GRP) begin
						col_q <= '0;
						if (row_q == nrms_pkg::LAST_GRP) begin
							row_q   <= '0;
							state_q <= ST_DRAIN;
						end else begin
							row_q <= row_q + nrms_pkg::GRP_W'(1);
						end
					end else begin
						col_q <= col_q + nrms_pkg::GRP_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!sts.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (row_q == nrms_pkg::LAST_GRP) begin
							row_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							row_q <= row_q + nrms_pkg::GRP_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/neural_rate_model_step.sv =====
// ----------------------------------------------------------------------------
// neural_rate_model_step
// Fixed-point firing-rate network advanced by forward Euler steps.
//
// Input channel req (req_valid / req_stall) carries one request per
// transaction: a weight write, a group settings write (rate, drive, gain) or
// a step. Writes give no result. A step walks all GROUPS*GROUPS weights
// through one multiply-accumulate unit, one weight per cycle out of the
// weight memory, then updates each group and emits GROUPS results on rsp
// (rsp_valid / rsp_stall) in group order, last_out on the final one.
// req_stall stays high from the cycle after the step is taken until the
// last result is issued.
// A stalled rsp holds its transaction; the sequencer waits until the result
// register frees and loses nothing. A new request is taken while the final
// result still waits. Reset clears all weights, rates, drives and gains to
// zero at once; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module neural_rate_model_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  nrms_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output nrms_pkg::rsp_t rsp
);

	nrms_pkg::cmd_t cmd;
	nrms_pkg::sts_t sts;

	nrms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	nrms_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// ===== test/tb_neural_rate_model_step.sv =====
// ----------------------------------------------------------------------------
// tb_neural_rate_model_step
// Self-checking bench for the firing-rate network step block. Requests load
// weights and group settings and advance the network by Euler steps. A
// scoreboard keeps its own copy of the network, predicts every group's new
// rate and compares each result transaction in order. Both channels see
// random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_neural_rate_model_step;
	import nrms_pkg::*;

	localparam longint     VAL_MAX      = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
	localparam longint     VAL_MIN      = -VAL_MAX - 1;
	localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
	localparam int         RANDOM_ITEMS = 360;
	localparam int         IDLE_LIMIT   = 4000;
	localparam int         DRAIN_CYCLES = 100;

	// Network copy, rate prediction and in-order result checking
	class rate_scoreboard;
		longint weights [WDEPTH];
		longint rates [GROUPS];
		longint drives [GROUPS];
		longint gains [GROUPS];
		rsp_t   expected_rates [$];
		int     errors;
		int     checked;
		int     steps;

		function longint clamp_store(longint x);
			if (x > VAL_MAX) return VAL_MAX;
			if (x < VAL_MIN) return VAL_MIN;
			return x;
		endfunction

		// all new rates come from the old ones, then commit together
		function void advance_network();
			longint next_rate [GROUPS];
			longint acc;
			longint level;
			longint diff;
			rsp_t   r;
			for (int i = 0; i < GROUPS; i++) begin
				acc = 0;
				for (int j = 0; j < GROUPS; j++) begin
					acc += weights[j * GROUPS + i] * rates[j];
				end
				level = (acc >>> FRAC_W) + drives[i];
				if (level < 0) level = 0;
				if (level > VAL_MAX) level = VAL_MAX;
				diff = level - rates[i];
				next_rate[i] = clamp_store(rates[i] + ((gains[i] * diff) >>> FRAC_W));
			end
			rates = next_rate;
			for (int i = 0; i < GROUPS; i++) begin
				r.group_out = GIDX_W'(i);
				r.rate_out  = next_rate[i][FIELD_W-1:0];
				r.last_out  = (i == GROUPS - 1);
				expected_rates.push_back(r);
			end
			steps++;
		endfunction

		function void note_request(req_t q);
			case (q.req_type)
			REQ_WEIGHT: begin
				if (q.target_group < GROUPS && q.source_group < GROUPS)
					weights[q.source_group * GROUPS + q.target_group] =
						clamp_store(longint'(q.value));
			end
			REQ_GROUP: begin
				if (q.target_group < GROUPS) begin
					rates[q.target_group]  = clamp_store(longint'(q.value));
					drives[q.target_group] = clamp_store(longint'(q.drive));
					gains[q.target_group]  = longint'(q.gain);
				end
			end
			REQ_STEP: advance_network();
			default: ;
			endcase
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_rates.size() == 0) begin
				$error("unexpected result: group %0d rate %0d", got.group_out, got.rate_out);
				errors++;
				return;
			end
			want = expected_rates.pop_front();
			checked++;
			if (got.group_out !== want.group_out) begin
				$error("group_out: expected %0d, got %0d", want.group_out, got.group_out);
				errors++;
			end
			if (got.rate_out !== want.rate_out) begin
				$error("rate_out: expected %0d, got %0d", want.rate_out, got.rate_out);
				errors++;
			end
			if (got.last_out !== want.last_out) begin
				$error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
				errors++;
			end
		endfunction

		function int pending();
			return expected_rates.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	rate_scoreboard sb = new;
	bit calm;
	int accepted;
	int ignored;
	int idle_cycles;

	neural_rate_model_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(input logic [1:0] kind, input logic [GIDX_W-1:0] tgt,
			input logic [GIDX_W-1:0] src, input logic [FIELD_W-1:0] value,
			input logic [FIELD_W-1:0] drive, input logic [GAIN_W-1:0] gain);
		req_t q;
		q.req_type     = kind;
		q.target_group = tgt;
		q.source_group = src;
		q.value        = value;
		q.drive        = drive;
		q.gain         = gain;
		return q;
	endfunction

	// rates and drives: mostly within +/-4.0, some extremes and full range
	function automatic logic [FIELD_W-1:0] pick_level();
		case ($urandom_range(0, 9))
		0: return 24'h7FFFFF;
		1: return 24'h800000;
		2, 3: return FIELD_W'($urandom);
		default: return FIELD_W'($urandom_range(0, 524288) - 262144);
		endcase
	endfunction

	// weights: mostly within +/-1.5
	function automatic logic [FIELD_W-1:0] pick_weight();
		case ($urandom_range(0, 19))
		0: return 24'h7FFFFF;
		1: return 24'h800000;
		2, 3: return FIELD_W'($urandom);
		default: return FIELD_W'($urandom_range(0, 196608) - 98304);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return GAIN_W'($urandom);
		endcase
	endfunction

	function automatic req_t random_write();
		if ($urandom_range(0, 99) < 40)
			return make_req(REQ_GROUP, GIDX_W'($urandom), GIDX_W'($urandom), pick_level(),
				pick_level(), pick_gain());
		return make_req(REQ_WEIGHT, GIDX_W'($urandom), GIDX_W'($urandom), pick_weight(),
			FIELD_W'($urandom), GAIN_W'($urandom));
	endfunction

	function automatic req_t random_noise();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(req_t)-1:0];
	endfunction

	// offer one transaction after an optional gap and hold it until taken
	task automatic send_req(input req_t q);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= q;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(q);
		if (q.req_type == REQ_UNKNOWN) ignored++;
		else accepted++;
	endtask

	// drop valid and hold off until every predicted rate is back
	task automatic wait_results_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_block();
		int r;
		int n;
		r    = $urandom_range(0, 99);
		calm = ($urandom_range(0, 99) < 15);
		if (r < 8) begin
			n = $urandom_range(1, 4);
			repeat (n) send_req(random_noise());
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) send_req(random_write());
			n = $urandom_range(1, 3);
			repeat (n) send_req(make_req(REQ_STEP, GIDX_W'($urandom), GIDX_W'($urandom),
				FIELD_W'($urandom), FIELD_W'($urandom), GAIN_W'($urandom)));
		end
		if (r >= 95) wait_results_drained();
	endtask

	// result side stall pattern
	initial begin
		int hold;
		int run;
		hold      = 0;
		run       = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= 1'b0;
				if (run > 0) begin
					run--;
				end else if (!calm) begin
					hold = pick_gap();
					run  = $urandom_range(0, 12);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_result(rsp);
	end

	// end the run if no transaction moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_neural_rate_model_step: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int directed_done;
		req_valid   = 1'b0;
		req         = '0;
		arst_n      = 1'b0;
		calm        = 1'b0;
		accepted    = 0;
		ignored     = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty network, extremes, self and cross coupling, unknown request
		send_req(make_req(REQ_STEP, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_GROUP, 0, 5, 24'h7FFFFF, 24'h800000, 16'hFFFF));
		send_req(make_req(REQ_GROUP, 7, 2, 24'h800000, 24'h7FFFFF, 16'h0000));
		send_req(make_req(REQ_WEIGHT, 0, 7, 24'h7FFFFF, 24'hFFFFFF, 16'hFFFF));
		send_req(make_req(REQ_WEIGHT, 7, 0, 24'h800000, 24'h000000, 16'h0000));
		send_req(make_req(REQ_WEIGHT, 0, 0, 24'h7FFFFF, 24'h123456, 16'hA5A5));
		send_req(make_req(REQ_UNKNOWN, 3, 4, 24'h7FFFFF, 24'h800000, 16'hFFFF));
		send_req(make_req(REQ_STEP, 7, 7, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
		send_req(make_req(REQ_STEP, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_GROUP, 3, 0, 24'h010000, 24'h008000, 16'h8000));
		send_req(make_req(REQ_WEIGHT, 3, 3, 24'h010000, 0, 0));
		send_req(make_req(REQ_WEIGHT, 5, 3, 24'hFF0000, 0, 0));
		send_req(make_req(REQ_GROUP, 5, 0, 24'hFF0000, 24'h020000, 16'h1000));
		send_req(make_req(REQ_STEP, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_STEP, 0, 0, 0, 0, 0));
		send_req(make_req(REQ_GROUP, 0, 0, 24'h000000, 24'h000000, 16'hFFFF));
		send_req(make_req(REQ_STEP, 0, 0, 0, 0, 0));
		wait_results_drained();
		directed_done = accepted;

		while (accepted - directed_done < RANDOM_ITEMS) random_block();

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests (%0d steps, %0d unknown dropped), %0d rates checked",
			accepted + ignored, sb.steps, ignored, sb.checked);
		$display("with random gaps and stalls on both channels and drained pauses.");
		if (sb.errors == 0) begin
			$display("tb_neural_rate_model_step: PASS");
		end else begin
			$display("tb_neural_rate_model_step: FAIL");
		end
		$finish;
	end

endmodule
